// ===== hdl/hbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbc_pkg
// Types, constants and the bucket reducer shared by the buffer cache modules.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int NUM_SLOTS   = 32;
    localparam int NUM_BUCKETS = 13;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int COUNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
    localparam int DEV_W       = 8;
    localparam int BLK_W       = 32;
    localparam int REFS_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = BLK_W / DIGIT_W;
    localparam int STEP_W      = $clog2(NUM_DIGITS + 1);
    localparam int RED_W       = BUCKET_W + DIGIT_W;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_NOT_IN_USE = 2'd2,
        ST_COUNT      = 2'd3
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [DEV_W-1:0]   dev;
        logic [BLK_W-1:0]   block_number;
        logic [SLOT_W-1:0]  buffer_index;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               need_disk_read;
        logic [REFS_W-1:0]  ref_count;
        status_t            status;
    } out_t;

    typedef struct packed {
        logic [DEV_W-1:0]   dev;
        logic [BLK_W-1:0]   block_number;
    } tag_t;

    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] bucket;
    } hash_res_t;

    // Reduce a value below NUM_BUCKETS*32 modulo NUM_BUCKETS by restoring steps.
    function automatic logic [BUCKET_W-1:0] bucket_reduce(input logic [RED_W-1:0] v);
        logic [RED_W-1:0] x;
        x = v;
        if (x >= RED_W'(NUM_BUCKETS * 16)) x = x - RED_W'(NUM_BUCKETS * 16);
        if (x >= RED_W'(NUM_BUCKETS * 8))  x = x - RED_W'(NUM_BUCKETS * 8);
        if (x >= RED_W'(NUM_BUCKETS * 4))  x = x - RED_W'(NUM_BUCKETS * 4);
        if (x >= RED_W'(NUM_BUCKETS * 2))  x = x - RED_W'(NUM_BUCKETS * 2);
        if (x >= RED_W'(NUM_BUCKETS))      x = x - RED_W'(NUM_BUCKETS);
        return x[BUCKET_W-1:0];
    endfunction

endpackage

// ===== hdl/hbc_hash.sv =====
// ----------------------------------------------------------------------------
// hbc_hash
// Iterative bucket hash: (3 * block) mod NUM_BUCKETS, one digit per cycle.
// ----------------------------------------------------------------------------
module hbc_hash (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [hbc_pkg::BLK_W-1:0] blk,
    output hbc_pkg::hash_res_t        res
);
    import hbc_pkg::*;

    logic [BLK_W-1:0]    blk_reg,  blk_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [BUCKET_W-1:0] rem_reg,  rem_next;
    logic [RED_W-1:0]    operand;
    logic [BUCKET_W+1:0] rem_x3;

    assign rem_x3 = {2'b00, rem_reg} + {1'b0, rem_reg, 1'b0};

    // Digits most significant first; the last step folds in the multiplier.
    always_comb begin
        if (step_reg == STEP_W'(NUM_DIGITS)) begin
            operand = RED_W'(rem_x3);
        end else begin
            operand = {rem_reg, blk_reg[BLK_W-1 -: DIGIT_W]};
        end
    end

    always_comb begin
        blk_next  = blk_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start) begin
            blk_next  = blk;
            step_next = '0;
            rem_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = bucket_reduce(operand);
            blk_next  = blk_reg << DIGIT_W;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_DIGITS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        rem_reg <= rem_next;
    end

    assign res.done   = done_reg;
    assign res.bucket = rem_reg;

endmodule

// ===== hdl/hbc_tag_ram.sv =====
// ----------------------------------------------------------------------------
// hbc_tag_ram
// Slot tag store (device, block number): one write port, registered read.
// ----------------------------------------------------------------------------
module hbc_tag_ram (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [hbc_pkg::SLOT_W-1:0] waddr,
    input  hbc_pkg::tag_t              wdata,
    input  logic [hbc_pkg::SLOT_W-1:0] raddr,
    output hbc_pkg::tag_t              rdata
);
    import hbc_pkg::*;

    tag_t mem [NUM_SLOTS];
    tag_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/hashed_block_buffer_cache.sv =====
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// Buffer slot cache with tag lookup by hash bucket, reference counts and a
// LIFO free list.
// ----------------------------------------------------------------------------
//  channel   ports                        payload  direction
//  request   s_valid s_ready s_payload    in_t     in
//  result    m_valid m_ready m_payload    out_t    out
//
//  Release, pin and unpin go from accept through S_MODIFY to S_RESP.
//  A read waits in S_HASH while the hash unit takes the block number one
//  4-bit digit per cycle and folds in the multiplier (9 steps); then each
//  in-use slot sharing its bucket costs one tag RAM read and one compare.
//  One item at a time: s_ready is high only while idle. A result waiting on
//  m_ready does not block acceptance; the next result waits for it.
//  Reset empties the table and fills the free list at once; no clearing pass.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hbc_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output hbc_pkg::out_t m_payload
);
    import hbc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HASH   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_CMP    = 6'b001000,
        S_MODIFY = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    in_t                 req_reg, req_next;
    logic [NUM_SLOTS-1:0] cand_reg, cand_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    out_t                res_reg, res_next;
    out_t                m_payload_reg, m_payload_next;
    logic                m_valid_reg, m_valid_next;
    logic [NUM_SLOTS-1:0] in_use_reg, in_use_next;
    logic [REFS_W-1:0]   refs_reg [NUM_SLOTS];
    logic [REFS_W-1:0]   refs_next [NUM_SLOTS];
    logic [SLOT_W-1:0]   free_stack_reg [NUM_SLOTS];
    logic [SLOT_W-1:0]   free_stack_next [NUM_SLOTS];
    logic [COUNT_W-1:0]  free_count_reg, free_count_next;
    logic [BUCKET_W-1:0] slot_bucket_reg [NUM_SLOTS];

    logic                hash_start;
    hash_res_t           hash_res;
    logic                tag_we;
    logic [SLOT_W-1:0]   tag_raddr;
    tag_t                tag_wdata;
    tag_t                tag_rdata;
    logic                out_load;

    logic [COUNT_W-1:0]  top_sum;
    logic [SLOT_W-1:0]   pop_slot;
    logic [SLOT_W-1:0]   first_idx;
    logic                tag_match;
    logic [REFS_W-1:0]   hit_refs;
    logic [REFS_W-1:0]   op_refs;
    logic [NUM_SLOTS-1:0] bucket_hits;

    hbc_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .blk     (s_payload.block_number),
        .res     (hash_res)
    );

    hbc_tag_ram u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (pop_slot),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    assign top_sum   = free_count_reg - 1'b1;
    assign pop_slot  = free_stack_reg[top_sum[SLOT_W-1:0]];
    assign hit_refs  = refs_reg[cur_reg];
    assign op_refs   = refs_reg[req_reg.buffer_index];
    assign tag_match = (tag_rdata.dev == req_reg.dev) &&
                       (tag_rdata.block_number == req_reg.block_number);
    assign tag_wdata.dev          = req_reg.dev;
    assign tag_wdata.block_number = req_reg.block_number;

    // Lowest candidate slot first.
    always_comb begin
        first_idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (cand_reg[k]) first_idx = SLOT_W'(k);
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            bucket_hits[k] = in_use_reg[k] && (slot_bucket_reg[k] == hash_res.bucket);
        end
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        cand_next       = cand_reg;
        cur_next        = cur_reg;
        bucket_next     = bucket_reg;
        res_next        = res_reg;
        m_payload_next  = m_payload_reg;
        m_valid_next    = m_valid_reg;
        in_use_next     = in_use_reg;
        refs_next       = refs_reg;
        free_stack_next = free_stack_reg;
        free_count_next = free_count_reg;
        hash_start      = 1'b0;
        tag_we          = 1'b0;
        tag_raddr       = cur_reg;
        out_load        = 1'b0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_payload;
                    if (s_payload.op == OP_READ) begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end else begin
                        state_next = S_MODIFY;
                    end
                end
            end
            S_HASH: begin
                if (hash_res.done) begin
                    bucket_next = hash_res.bucket;
                    cand_next   = bucket_hits;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                res_next.hit = 1'b0;
                if (cand_reg == '0) begin
                    // Miss: take the slot on top of the free list.
                    if (free_count_reg == '0) begin
                        res_next.slot           = '0;
                        res_next.need_disk_read = 1'b0;
                        res_next.ref_count      = '0;
                        res_next.status         = ST_NO_FREE;
                    end else begin
                        free_count_next       = top_sum;
                        in_use_next[pop_slot] = 1'b1;
                        refs_next[pop_slot]   = REFS_W'(1);
                        tag_we                = 1'b1;
                        res_next.slot           = pop_slot;
                        res_next.need_disk_read = 1'b1;
                        res_next.ref_count      = REFS_W'(1);
                        res_next.status         = ST_OK;
                    end
                    state_next = S_RESP;
                end else begin
                    tag_raddr            = first_idx;
                    cur_next             = first_idx;
                    cand_next[first_idx] = 1'b0;
                    state_next           = S_CMP;
                end
            end
            S_CMP: begin
                if (tag_match) begin
                    res_next.slot           = cur_reg;
                    res_next.hit            = 1'b1;
                    res_next.need_disk_read = 1'b0;
                    if (hit_refs == REFS_MAX) begin
                        res_next.ref_count = hit_refs;
                        res_next.status    = ST_COUNT;
                    end else begin
                        refs_next[cur_reg] = hit_refs + 1'b1;
                        res_next.ref_count = hit_refs + 1'b1;
                        res_next.status    = ST_OK;
                    end
                    state_next = S_RESP;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_MODIFY: begin
                res_next.slot           = req_reg.buffer_index;
                res_next.hit            = 1'b0;
                res_next.need_disk_read = 1'b0;
                res_next.ref_count      = op_refs;
                res_next.status         = ST_OK;
                if (!in_use_reg[req_reg.buffer_index]) begin
                    res_next.status = ST_NOT_IN_USE;
                end else if (req_reg.op == OP_PIN) begin
                    if (op_refs == REFS_MAX) begin
                        res_next.status = ST_COUNT;
                    end else begin
                        refs_next[req_reg.buffer_index] = op_refs + 1'b1;
                        res_next.ref_count              = op_refs + 1'b1;
                    end
                end else if (op_refs == '0) begin
                    res_next.status = ST_COUNT;
                end else begin
                    refs_next[req_reg.buffer_index] = op_refs - 1'b1;
                    res_next.ref_count              = op_refs - 1'b1;
                    // Release to zero: drop the slot and push it on the free list.
                    if (req_reg.op == OP_RELEASE && op_refs == REFS_W'(1)) begin
                        in_use_next[req_reg.buffer_index] = 1'b0;
                        if (free_count_reg < COUNT_W'(NUM_SLOTS)) begin
                            free_stack_next[free_count_reg[SLOT_W-1:0]] =
                                req_reg.buffer_index;
                            free_count_next = free_count_reg + 1'b1;
                        end
                    end
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_payload_next = res_reg;
                    m_valid_next   = 1'b1;
                    out_load       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            in_use_reg     <= '0;
            free_count_reg <= COUNT_W'(NUM_SLOTS);
            for (int k = 0; k < NUM_SLOTS; k++) begin
                refs_reg[k]       <= '0;
                free_stack_reg[k] <= SLOT_W'(k);
            end
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            in_use_reg     <= in_use_next;
            free_count_reg <= free_count_next;
            refs_reg       <= refs_next;
            free_stack_reg <= free_stack_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        cand_reg      <= cand_next;
        cur_reg       <= cur_next;
        bucket_reg    <= bucket_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
        if (tag_we) begin
            slot_bucket_reg[pop_slot] <= bucket_reg;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Free slots and in-use slots always add up to NUM_SLOTS.
    a_slot_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(free_count_reg) + $countones(in_use_reg)) == NUM_SLOTS)
        else $error("free list and in-use slots out of balance");

    // One transaction at a time: no accept right after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // A slot handed out for a disk read is marked in use.
    a_alloc_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_reg.need_disk_read) |=> in_use_reg[m_payload.slot])
        else $error("allocated slot not in use");

    // The hash unit only finishes while the sequencer waits for it.
    a_hash_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_res.done |-> (state_reg == S_HASH))
        else $error("hash result outside hash wait");

endmodule

// ===== tb/hashed_block_buffer_cache_tb.sv =====
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_tb
// Drives read, release, pin and unpin requests into the buffer cache and
// checks every result against a cycle-free model of the slot table, free
// list and reference counts kept alongside it. Both channels idle at random.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hbc_pkg::*;

    logic  aclk      = 1'b0;
    logic  aresetn   = 1'b0;
    logic  s_valid   = 1'b0;
    logic  s_ready;
    in_t   s_payload = '0;
    logic  m_valid;
    logic  m_ready   = 1'b0;
    out_t  m_payload;

    hashed_block_buffer_cache DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Slot table as the cache should hold it
    logic              used     [NUM_SLOTS];
    logic [DEV_W-1:0]  tag_dev  [NUM_SLOTS];
    logic [BLK_W-1:0]  tag_blk  [NUM_SLOTS];
    logic [REFS_W-1:0] refs     [NUM_SLOTS];
    logic [SLOT_W-1:0] free_list[NUM_SLOTS];
    int                free_top;

    out_t pending_results[$];
    out_t last_reply;
    out_t oldest;
    int   mismatches = 0;
    int   hold_left  = 0;
    bit   no_idle    = 1'b0;

    function automatic out_t cache_apply(input in_t req);
        out_t              r;
        int                found;
        logic [SLOT_W-1:0] s;
        r        = '0;
        r.slot   = req.buffer_index;
        r.status = ST_OK;
        if (req.op == OP_READ) begin
            found = -1;
            // tags of in-use slots are unique, so bucket order does not matter
            for (int k = 0; k < NUM_SLOTS; k++)
                if (used[k] && tag_dev[k] == req.dev && tag_blk[k] == req.block_number)
                    found = k;
            if (found >= 0) begin
                r.slot = SLOT_W'(found);
                r.hit  = 1'b1;
                if (refs[found] == REFS_MAX)
                    r.status = ST_COUNT;
                else
                    refs[found] = refs[found] + 1'b1;
                r.ref_count = refs[found];
            end else if (free_top == 0) begin
                r.slot   = '0;
                r.status = ST_NO_FREE;
            end else begin
                free_top--;
                s          = free_list[free_top];
                used[s]    = 1'b1;
                tag_dev[s] = req.dev;
                tag_blk[s] = req.block_number;
                refs[s]    = REFS_W'(1);
                r.slot           = s;
                r.need_disk_read = 1'b1;
                r.ref_count      = REFS_W'(1);
            end
        end else if (!used[req.buffer_index]) begin
            r.ref_count = refs[req.buffer_index];
            r.status    = ST_NOT_IN_USE;
        end else if (req.op == OP_PIN) begin
            if (refs[req.buffer_index] == REFS_MAX)
                r.status = ST_COUNT;
            else
                refs[req.buffer_index] = refs[req.buffer_index] + 1'b1;
            r.ref_count = refs[req.buffer_index];
        end else if (refs[req.buffer_index] == 0) begin
            r.status = ST_COUNT;
        end else begin
            refs[req.buffer_index] = refs[req.buffer_index] - 1'b1;
            r.ref_count = refs[req.buffer_index];
            // only release frees the slot; unpin to zero keeps it tagged
            if (req.op == OP_RELEASE && refs[req.buffer_index] == 0) begin
                used[req.buffer_index] = 1'b0;
                if (free_top < NUM_SLOTS) begin
                    free_list[free_top] = req.buffer_index;
                    free_top++;
                end
            end
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 96) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic send_request(input in_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        last_reply = cache_apply(req);
        pending_results.push_back(last_reply);
    endtask

    task automatic run_op(input op_t op, input logic [DEV_W-1:0] dev,
                          input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] idx);
        in_t req;
        req.op           = op;
        req.dev          = dev;
        req.block_number = blk;
        req.buffer_index = idx;
        send_request(req);
    endtask

    // Result side: random back-pressure, then compare with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: slot %0d hit %0d disk %0d refs %0d status %0d",
                             m_payload.slot, m_payload.hit, m_payload.need_disk_read,
                             m_payload.ref_count, m_payload.status);
            end else begin
                oldest = pending_results.pop_front();
                if (m_payload.slot !== oldest.slot || m_payload.hit !== oldest.hit ||
                    m_payload.need_disk_read !== oldest.need_disk_read ||
                    m_payload.ref_count !== oldest.ref_count ||
                    m_payload.status !== oldest.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected slot %0d hit %0d disk %0d refs %0d status %0d, got slot %0d hit %0d disk %0d refs %0d status %0d",
                                 oldest.slot, oldest.hit, oldest.need_disk_read,
                                 oldest.ref_count, oldest.status,
                                 m_payload.slot, m_payload.hit, m_payload.need_disk_read,
                                 m_payload.ref_count, m_payload.status);
                end
            end
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(3) == 0) hold_left = pick_gap();
        end
    end

    task automatic test_basic_ops();
        run_op(OP_READ, 8'h00, 32'h0000_0000, 5'd0);
        run_op(OP_READ, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        run_op(OP_READ, 8'h00, 32'h0000_0000, 5'd0);     // hit
        run_op(OP_READ, 8'h01, 32'h0000_0000, 5'd0);     // same block, other device
        run_op(OP_READ, 8'h00, 32'd13, 5'd0);            // same bucket as block 0
        run_op(OP_PIN, 8'h00, 32'h0, 5'd31);
        run_op(OP_UNPIN, 8'h00, 32'h0, 5'd31);
        run_op(OP_UNPIN, 8'h00, 32'h0, 5'd31);
        run_op(OP_UNPIN, 8'h00, 32'h0, 5'd31);           // down to zero, still tagged
        run_op(OP_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd31);   // underflow
        run_op(OP_RELEASE, 8'h00, 32'h0, 5'd31);         // underflow
        run_op(OP_READ, 8'h00, 32'h0000_0000, 5'd31);    // hit on zero-count slot
        run_op(OP_RELEASE, 8'h00, 32'h0, 5'd31);         // frees it
        run_op(OP_RELEASE, 8'h00, 32'h0, 5'd31);
        run_op(OP_PIN, 8'h00, 32'h0, 5'd31);
        run_op(OP_UNPIN, 8'h00, 32'h0, 5'd31);
        run_op(OP_READ, 8'hA5, 32'h5A5A_5A5A, 5'd0);     // reuses the slot just freed
        run_op(OP_PIN, 8'h00, 32'h0, 5'd0);              // never used
        run_op(OP_RELEASE, 8'h00, 32'h0, 5'd30);
        run_op(OP_RELEASE, 8'h00, 32'h0, 5'd29);
        run_op(OP_RELEASE, 8'h00, 32'h0, 5'd28);
        run_op(OP_RELEASE, 8'h00, 32'h0, 5'd31);
    endtask

    task automatic test_full_table();
        // every tag in one bucket: longest search
        for (int k = 0; k < NUM_SLOTS; k++)
            run_op(OP_READ, DEV_W'(k), BLK_W'(7 + 13 * k), SLOT_W'($urandom));
        run_op(OP_READ, 8'hEE, 32'h1234_5678, 5'd0);     // no free slot
        run_op(OP_READ, 8'd5, 32'd72, 5'd0);             // hit while full
        for (int k = 0; k < NUM_SLOTS; k++)
            while (used[k])
                run_op(OP_RELEASE, 8'($urandom), $urandom, SLOT_W'(k));
    endtask

    task automatic test_count_limits();
        logic [SLOT_W-1:0] s;
        op_t               op;
        run_op(OP_READ, 8'h3C, 32'hC0FF_EE00, 5'd0);
        s = last_reply.slot;
        repeat (254) run_op(OP_PIN, 8'($urandom), $urandom, s);
        run_op(OP_PIN, 8'h00, 32'h0, s);                 // overflow
        run_op(OP_READ, 8'h3C, 32'hC0FF_EE00, 5'd0);     // hit at the ceiling
        run_op(OP_UNPIN, 8'h00, 32'h0, s);
        run_op(OP_PIN, 8'h00, 32'h0, s);
        // drain back down; release at one so the slot returns to the free list
        while (used[s]) begin
            if (refs[s] == 1 || $urandom_range(1) == 0)
                op = OP_RELEASE;
            else
                op = OP_UNPIN;
            run_op(op, 8'($urandom), $urandom, s);
        end
    endtask

    task automatic test_random_traffic(input int count);
        tag_t              pool[10];
        logic [BLK_W-1:0]  base;
        int                busy[$];
        int                r;
        tag_t              tg;
        logic [SLOT_W-1:0] idx;
        op_t               op;
        base = $urandom_range(32'h0FFF_FFFF);
        for (int k = 0; k < 5; k++)
            pool[k] = {8'($urandom), base + BLK_W'(13 * k * ($urandom_range(50) + 1))};
        for (int k = 5; k < 8; k++)
            pool[k] = {pool[0].dev + DEV_W'(k - 4), pool[0].block_number};
        for (int k = 8; k < 10; k++)
            pool[k] = {8'($urandom), 32'($urandom)};
        for (int n = 0; n < count; n++) begin
            if (n % 80 == 0) no_idle = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < 40) begin
                if ($urandom_range(3) != 0)
                    tg = pool[$urandom_range(9)];
                else
                    tg = {8'($urandom), 32'($urandom)};
                run_op(OP_READ, tg.dev, tg.block_number, SLOT_W'($urandom));
            end else begin
                op = (r < 65) ? OP_RELEASE : (r < 82) ? OP_PIN : OP_UNPIN;
                busy.delete();
                for (int k = 0; k < NUM_SLOTS; k++)
                    if (used[k]) busy.push_back(k);
                if (busy.size() != 0 && $urandom_range(99) < 85)
                    idx = SLOT_W'(busy[$urandom_range(busy.size() - 1)]);
                else
                    idx = SLOT_W'($urandom);
                run_op(op, 8'($urandom), $urandom, idx);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            used[k]      = 1'b0;
            tag_dev[k]   = '0;
            tag_blk[k]   = '0;
            refs[k]      = '0;
            free_list[k] = SLOT_W'(k);
        end
        free_top = NUM_SLOTS;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_full_table();
        test_count_limits();
        test_random_traffic(500);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("hashed_block_buffer_cache_tb passed");
        else
            $display("hashed_block_buffer_cache_tb failed");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("hashed_block_buffer_cache_tb failed");
        $finish;
    end

endmodule
